/* rtl/fsa_pkg.sv */
// fsa_pkg: shared constants for the fragmented sparse array core
// op, status and event codes, default sizes, register clamp helper
// no dependencies
package fsa_pkg;

  // default sizes
  localparam int DEF_MAX_FRAGMENTS      = 64;
  localparam int DEF_MAX_FRAGMENT_CELLS = 64;
  localparam int DEF_DATA_WIDTH         = 32;

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int IDX_W   = 16;
  localparam int KEY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 13;
  localparam int FRAG_W  = 7;
  localparam int EVT_W   = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // positive part of the index, divided one bit a cycle
  localparam int DIV_BITS = IDX_W - 1;

  // op codes
  localparam logic [OP_W-1:0] OP_SET      = 3'd0;
  localparam logic [OP_W-1:0] OP_GET      = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_IS_SET   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_SET = 2'd2;

  // fragment events
  localparam logic [EVT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVT_W-1:0] EV_SPAWN = 2'd1;
  localparam logic [EVT_W-1:0] EV_FREE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_SIZE  = 1'b1;

  // zero reads as one, above the maximum reads as the maximum
  function automatic int clamp_reg(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

/* rtl/fragmented_sparse_array_core.sv */
// fragmented_sparse_array_core: sparse array in lazily allocated fragments
// one sequencer around a shared divide/compare datapath and three memories
// depends on fsa_pkg
//
// channel | ports                                         | handshake
// input   | in_op, in_cell_index, in_key                  | start while busy low
// result  | out_status .. out_fragment_event              | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_wdata                  | write on cfg_we while idle
//
// set/get/delete/is_set with a valid index: the divide steps, then a read, an
// execute and a result state; a set that spawns a fragment first clears every
// cell of it in S_SPAWN and then executes a second time
// contains_key: skips each inactive fragment, reads then compares each scanned
// cell, checks the end unless a hit stops the scan, then the result state
// invalid index, clear and unused ops go straight to the result state; results
// leave in the cycle after the item ends
// reset leaves all fragments inactive with no clearing pass; the receiver
// cannot stall, so out_valid lasts exactly one cycle
module fragmented_sparse_array_core #(
  parameter int MAX_FRAGMENTS      = fsa_pkg::DEF_MAX_FRAGMENTS,
  parameter int MAX_FRAGMENT_CELLS = fsa_pkg::DEF_MAX_FRAGMENT_CELLS,
  parameter int DATA_WIDTH         = fsa_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [fsa_pkg::OP_W-1:0]           in_op,
  input  logic signed [fsa_pkg::IDX_W-1:0]   in_cell_index,
  input  logic signed [fsa_pkg::KEY_W-1:0]   in_key,
  output logic                               out_valid,
  output logic [fsa_pkg::STAT_W-1:0]         out_status,
  output logic signed [fsa_pkg::KEY_W-1:0]   out_read_value,
  output logic                               out_found,
  output logic [fsa_pkg::CNT_W-1:0]          out_element_count,
  output logic [fsa_pkg::FRAG_W-1:0]         out_active_fragments,
  output logic [fsa_pkg::CNT_W-1:0]          out_allocated_cells,
  output logic [fsa_pkg::CNT_W-1:0]          out_capacity,
  output logic [fsa_pkg::EVT_W-1:0]          out_fragment_event,
  input  logic                               cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsa_pkg::CFG_W-1:0]          cfg_wdata
);
  import fsa_pkg::*;

  localparam int FW   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CW   = (MAX_FRAGMENT_CELLS > 1) ? $clog2(MAX_FRAGMENT_CELLS) : 1;
  localparam int FCW  = $clog2(MAX_FRAGMENTS + 1);
  localparam int FSW  = $clog2(MAX_FRAGMENT_CELLS + 1);
  localparam int AW   = FW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int TW   = $clog2(MAX_FRAGMENTS * MAX_FRAGMENT_CELLS + 1);
  localparam int CAPW = FCW + FSW;
  localparam int DCW  = $clog2(DIV_BITS + 1);
  localparam int IXW  = (CAPW > DIV_BITS) ? CAPW : DIV_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOOKUP, S_EXEC, S_SPAWN, S_SCAN_RD, S_SCAN_CMP, S_RESP
  } state_t;

  state_t state_r;

  // configuration and bookkeeping
  logic [FCW-1:0]          frag_count_r;
  logic [FSW-1:0]          frag_size_r;
  logic [MAX_FRAGMENTS-1:0] active_r;
  logic [TW-1:0]           valid_total_r;
  logic [FCW-1:0]          active_total_r;

  // item registers
  logic [OP_W-1:0]         op_r;
  logic [DATA_WIDTH-1:0]   key_r;
  logic [DIV_BITS-1:0]     quo_r;
  logic [FSW-1:0]          rem_r;
  logic [DCW-1:0]          div_cnt_r;
  logic [FCW-1:0]          scan_f_r;
  logic [FSW-1:0]          scan_c_r;
  logic                    fresh_r;
  logic [STAT_W-1:0]       status_r;
  logic [KEY_W-1:0]        value_r;
  logic                    found_r;
  logic [EVT_W-1:0]        event_r;

  // memories and registered read data
  logic [DATA_WIDTH-1:0]   val_mem [DEPTH];
  logic                    vld_mem [DEPTH];
  logic [FSW-1:0]          fill_mem [MAX_FRAGMENTS];
  logic [DATA_WIDTH-1:0]   val_q_r;
  logic                    vld_q_r;
  logic [FSW-1:0]          fill_q_r;

  // output registers
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [KEY_W-1:0]        out_value_r;
  logic                    out_found_r;
  logic [CNT_W-1:0]        out_elem_r;
  logic [FRAG_W-1:0]       out_act_r;
  logic [CNT_W-1:0]        out_alloc_r;
  logic [CNT_W-1:0]        out_cap_r;
  logic [EVT_W-1:0]        out_event_r;

  // combinational datapath
  logic [CAPW-1:0]         capacity;
  logic                    idx_ok;
  logic [FW-1:0]           frag;
  logic [CW-1:0]           off;
  logic [AW-1:0]           addr;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [FSW:0]            div_trial;
  logic                    div_take;
  logic                    act;
  logic                    vld_eff;
  logic [FSW-1:0]          fill_eff;
  logic                    val_we;
  logic                    vld_we;
  logic                    vld_wd;
  logic                    fill_we;
  logic [FSW-1:0]          fill_wd;
  logic                    scan_hit;
  logic                    scan_last_c;

  assign capacity = CAPW'(frag_count_r) * CAPW'(frag_size_r);
  assign idx_ok   = !in_cell_index[IDX_W-1] &&
                    (IXW'(in_cell_index[IDX_W-2:0]) < IXW'(capacity));

  // quotient is the fragment, remainder the offset
  assign frag = quo_r[FW-1:0];
  assign off  = rem_r[CW-1:0];
  assign addr = {frag, off};

  // one restoring divide step
  assign div_trial = {rem_r, quo_r[DIV_BITS-1]};
  assign div_take  = div_trial >= (FSW+1)'(frag_size_r);

  // a freshly spawned fragment reads as empty
  assign act      = active_r[frag];
  assign vld_eff  = vld_q_r && !fresh_r;
  assign fill_eff = fresh_r ? '0 : fill_q_r;

  assign scan_hit    = vld_q_r && (val_q_r == key_r);
  assign scan_last_c = (scan_c_r + FSW'(1)) == frag_size_r;

  assign rd_addr = (state_r == S_SCAN_RD) ?
                   {scan_f_r[FW-1:0], scan_c_r[CW-1:0]} : addr;
  assign wr_addr = (state_r == S_SPAWN) ? {frag, scan_c_r[CW-1:0]} : addr;

  // memory write controls
  always_comb begin
    val_we  = 1'b0;
    vld_we  = 1'b0;
    vld_wd  = 1'b0;
    fill_we = 1'b0;
    fill_wd = fill_eff;
    if (state_r == S_SPAWN) begin
      vld_we = 1'b1;
    end else if (state_r == S_EXEC) begin
      if (op_r == OP_SET && act) begin
        val_we  = 1'b1;
        vld_we  = 1'b1;
        vld_wd  = 1'b1;
        fill_we = !vld_eff;
        fill_wd = fill_eff + FSW'(1);
      end else if (op_r == OP_DELETE && act && vld_eff) begin
        vld_we  = 1'b1;
        fill_we = 1'b1;
        fill_wd = fill_eff - FSW'(1);
      end
    end
  end

  // cell values
  always_ff @(posedge clk) begin
    if (val_we) val_mem[wr_addr] <= key_r;
    val_q_r <= val_mem[rd_addr];
  end

  // cell valid bits, only meaningful inside an active fragment
  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[wr_addr] <= vld_wd;
    vld_q_r <= vld_mem[rd_addr];
  end

  // fragment fill counts
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[frag] <= fill_wd;
    fill_q_r <= fill_mem[frag];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frag_count_r   <= FCW'(1);
      frag_size_r    <= FSW'(1);
      active_r       <= '0;
      valid_total_r  <= '0;
      active_total_r <= '0;
      out_valid_r    <= 1'b0;
      fresh_r        <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_RESP);
      unique case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_index == REG_FRAG_COUNT) begin
              frag_count_r <= FCW'(clamp_reg(cfg_wdata, MAX_FRAGMENTS));
            end else begin
              frag_size_r <= FSW'(clamp_reg(cfg_wdata, MAX_FRAGMENT_CELLS));
            end
            active_r       <= '0;
            valid_total_r  <= '0;
            active_total_r <= '0;
          end else if (start) begin
            op_r      <= in_op;
            key_r     <= DATA_WIDTH'(in_key);
            quo_r     <= in_cell_index[DIV_BITS-1:0];
            rem_r     <= '0;
            div_cnt_r <= '0;
            scan_f_r  <= '0;
            scan_c_r  <= '0;
            fresh_r   <= 1'b0;
            status_r  <= ST_OK;
            value_r   <= '0;
            found_r   <= 1'b0;
            event_r   <= EV_NONE;
            if (in_op == OP_CONTAINS) begin
              state_r <= S_SCAN_RD;
            end else if (in_op == OP_CLEAR) begin
              active_r       <= '0;
              valid_total_r  <= '0;
              active_total_r <= '0;
              state_r        <= S_RESP;
            end else if (in_op > OP_CLEAR) begin
              state_r <= S_RESP;
            end else if (!idx_ok) begin
              status_r <= ST_BAD_IDX;
              state_r  <= S_RESP;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r     <= div_take ? FSW'(div_trial - (FSW+1)'(frag_size_r))
                                : FSW'(div_trial);
          quo_r     <= {quo_r[DIV_BITS-2:0], div_take};
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(DIV_BITS - 1)) state_r <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= (op_r == OP_SET && !act) ? S_SPAWN : S_RESP;
          case (op_r)
            OP_SET: begin
              if (!act) begin
                scan_c_r <= '0;
              end else if (!vld_eff) begin
                valid_total_r <= valid_total_r + TW'(1);
              end
            end
            OP_GET: begin
              if (act && vld_eff) value_r <= KEY_W'($signed(val_q_r));
              else status_r <= ST_NOT_SET;
            end
            OP_DELETE: begin
              if (act && vld_eff) begin
                valid_total_r <= valid_total_r - TW'(1);
                if (fill_eff == FSW'(1)) begin
                  active_r[frag] <= 1'b0;
                  active_total_r <= active_total_r - FCW'(1);
                  event_r        <= EV_FREE;
                end
              end else begin
                status_r <= ST_NOT_SET;
              end
            end
            default: begin
              found_r <= act && vld_eff;
            end
          endcase
        end
        S_SPAWN: begin
          // clear every cell of the new fragment, then redo the set
          scan_c_r <= scan_c_r + FSW'(1);
          if (scan_last_c) begin
            active_r[frag] <= 1'b1;
            active_total_r <= active_total_r + FCW'(1);
            event_r        <= EV_SPAWN;
            fresh_r        <= 1'b1;
            state_r        <= S_EXEC;
          end
        end
        S_SCAN_RD: begin
          if (scan_f_r >= frag_count_r) begin
            state_r <= S_RESP;
          end else if (!active_r[scan_f_r[FW-1:0]]) begin
            scan_f_r <= scan_f_r + FCW'(1);
            scan_c_r <= '0;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (scan_hit) begin
            found_r <= 1'b1;
            state_r <= S_RESP;
          end else begin
            if (scan_last_c) begin
              scan_f_r <= scan_f_r + FCW'(1);
              scan_c_r <= '0;
            end else begin
              scan_c_r <= scan_c_r + FSW'(1);
            end
            state_r <= S_SCAN_RD;
          end
        end
        S_RESP: begin
          out_status_r <= status_r;
          out_value_r  <= value_r;
          out_found_r  <= found_r;
          out_elem_r   <= CNT_W'(valid_total_r);
          out_act_r    <= FRAG_W'(active_total_r);
          out_alloc_r  <= CNT_W'(CAPW'(active_total_r) * CAPW'(frag_size_r));
          out_cap_r    <= CNT_W'(capacity);
          out_event_r  <= event_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_read_value       = out_value_r;
  assign out_found            = out_found_r;
  assign out_element_count    = out_elem_r;
  assign out_active_fragments = out_act_r;
  assign out_allocated_cells  = out_alloc_r;
  assign out_capacity         = out_cap_r;
  assign out_fragment_event   = out_event_r;

endmodule

/* bench/tb_fragmented_sparse_array_core.sv */
// tb_fragmented_sparse_array_core: self-checking bench for the sparse array core
// directed and random request streams checked against an in-bench array model
// depends on fsa_pkg and fragmented_sparse_array_core
`timescale 1ns / 1ps

module tb_fragmented_sparse_array_core;
  import fsa_pkg::*;

  localparam int NFRAG = 64;
  localparam int NCELL = 64;
  localparam int IDLE_LIMIT = 50000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  read_value;
    logic              found;
    logic [CNT_W-1:0]  element_count;
    logic [FRAG_W-1:0] active_fragments;
    logic [CNT_W-1:0]  allocated_cells;
    logic [CNT_W-1:0]  capacity;
    logic [EVT_W-1:0]  fragment_event;
  } array_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_op = '0;
  logic signed [IDX_W-1:0] in_cell_index = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic out_valid;
  logic [STAT_W-1:0] out_status;
  logic signed [KEY_W-1:0] out_read_value;
  logic out_found;
  logic [CNT_W-1:0] out_element_count;
  logic [FRAG_W-1:0] out_active_fragments;
  logic [CNT_W-1:0] out_allocated_cells;
  logic [CNT_W-1:0] out_capacity;
  logic [EVT_W-1:0] out_fragment_event;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fragmented_sparse_array_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_cell_index(in_cell_index), .in_key(in_key),
    .out_valid(out_valid), .out_status(out_status), .out_read_value(out_read_value),
    .out_found(out_found), .out_element_count(out_element_count),
    .out_active_fragments(out_active_fragments),
    .out_allocated_cells(out_allocated_cells), .out_capacity(out_capacity),
    .out_fragment_event(out_fragment_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // array model state
  logic [KEY_W-1:0] cell_val [NFRAG*NCELL];
  logic             cell_set [NFRAG*NCELL];
  logic             frag_live [NFRAG];
  int               frag_fill [NFRAG];
  int               set_total, live_total;
  int               frag_cnt, frag_len;

  array_reply_t pending_replies[$];
  int errors, mismatches, items_sent, replies_seen, spawns_seen, frees_seen;
  int idle_cycles;
  int burst_left;
  bit gaps_on;
  logic [KEY_W-1:0] key_pool [8];

  function automatic void wipe_array();
    for (int i = 0; i < NFRAG*NCELL; i++) cell_set[i] = 1'b0;
    for (int f = 0; f < NFRAG; f++) begin
      frag_live[f] = 1'b0;
      frag_fill[f] = 0;
    end
    set_total = 0;
    live_total = 0;
  endfunction

  // expected reply for one request, updating the model
  function automatic array_reply_t model_request(logic [OP_W-1:0] op,
                                                 logic signed [IDX_W-1:0] idx,
                                                 logic [KEY_W-1:0] key);
    array_reply_t r;
    int cap, fr, addr;
    bit ok;
    r = '0;
    cap = frag_cnt * frag_len;
    ok = (idx >= 0) && (int'(idx) < cap);
    fr = ok ? int'(idx) / frag_len : 0;
    addr = ok ? fr * NCELL + int'(idx) % frag_len : 0;
    if (op <= OP_IS_SET && !ok) begin
      r.status = ST_BAD_IDX;
    end else begin
      case (op)
        OP_SET: begin
          if (!frag_live[fr]) begin
            frag_live[fr] = 1'b1;
            frag_fill[fr] = 0;
            live_total++;
            for (int c = 0; c < NCELL; c++) cell_set[fr*NCELL+c] = 1'b0;
            r.fragment_event = EV_SPAWN;
          end
          if (!cell_set[addr]) begin
            cell_set[addr] = 1'b1;
            frag_fill[fr]++;
            set_total++;
          end
          cell_val[addr] = key;
        end
        OP_GET: begin
          if (frag_live[fr] && cell_set[addr]) r.read_value = cell_val[addr];
          else r.status = ST_NOT_SET;
        end
        OP_DELETE: begin
          if (frag_live[fr] && cell_set[addr]) begin
            cell_set[addr] = 1'b0;
            frag_fill[fr]--;
            set_total--;
            if (frag_fill[fr] == 0) begin
              frag_live[fr] = 1'b0;
              live_total--;
              r.fragment_event = EV_FREE;
            end
          end else begin
            r.status = ST_NOT_SET;
          end
        end
        OP_IS_SET: r.found = frag_live[fr] && cell_set[addr];
        OP_CONTAINS: begin
          for (int f = 0; f < frag_cnt; f++) begin
            if (frag_live[f]) begin
              for (int c = 0; c < frag_len; c++) begin
                if (cell_set[f*NCELL+c] && cell_val[f*NCELL+c] == key) r.found = 1'b1;
              end
            end
          end
        end
        OP_CLEAR: wipe_array();
        default: ;
      endcase
    end
    r.element_count = CNT_W'(set_total);
    r.active_fragments = FRAG_W'(live_total);
    r.allocated_cells = CNT_W'(live_total * frag_len);
    r.capacity = CNT_W'(cap);
    return r;
  endfunction

  // sender idling: bursts with random gaps
  task automatic pace();
    if (gaps_on && burst_left <= 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // send one item, called at a falling edge
  task automatic send_item(logic [OP_W-1:0] op, logic signed [IDX_W-1:0] idx,
                           logic [KEY_W-1:0] key);
    pace();
    in_op = op;
    in_cell_index = idx;
    in_key = key;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(model_request(op, idx, key));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic int clamp_val(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // wait for the array to drain, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FRAG_COUNT) frag_cnt = clamp_val(val, NFRAG);
    else frag_len = clamp_val(val, NCELL);
    wipe_array();
  endtask

  task automatic set_shape(logic [CFG_W-1:0] cnt, logic [CFG_W-1:0] len);
    write_reg(REG_FRAG_COUNT, cnt);
    write_reg(REG_FRAG_SIZE, len);
  endtask

  // one random request shaped by the current capacity
  task automatic random_item();
    int cap, pick;
    logic [OP_W-1:0] op;
    logic signed [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    cap = frag_cnt * frag_len;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_SET;
    else if (pick < 50) op = OP_GET;
    else if (pick < 70) op = OP_DELETE;
    else if (pick < 80) op = OP_IS_SET;
    else if (pick < 90) op = OP_CONTAINS;
    else if (pick < 92) op = OP_CLEAR;
    else if (pick < 94) op = OP_W'($urandom_range(6, 7));
    else op = OP_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) idx = IDX_W'($urandom);
    else if (pick == 1) idx = IDX_W'(cap + $urandom_range(0, 3));
    else idx = IDX_W'($urandom_range(0, cap - 1));
    key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, 7)];
    send_item(op, idx, key);
  endtask

  task automatic test_directed();
    set_shape(7'd4, 7'd4);
    send_item(OP_GET, 16'sd0, 32'd0);
    send_item(OP_SET, 16'sd0, 32'h7fffffff);
    send_item(OP_SET, 16'sd0, 32'h80000000);
    send_item(OP_SET, 16'sd15, 32'hffffffff);
    send_item(OP_GET, 16'sd0, 32'd0);
    send_item(OP_IS_SET, 16'sd15, 32'd0);
    send_item(OP_IS_SET, 16'sd14, 32'd0);
    send_item(OP_CONTAINS, 16'sd0, 32'hffffffff);
    send_item(OP_CONTAINS, -16'sd1, 32'h12345678);
    send_item(OP_SET, 16'sd16, 32'd1);
    send_item(OP_GET, -16'sd32768, 32'd0);
    send_item(OP_IS_SET, 16'sd32767, 32'd0);
    send_item(OP_DELETE, 16'sd14, 32'd0);
    send_item(OP_DELETE, 16'sd15, 32'd0);
    send_item(OP_DELETE, 16'sd15, 32'd0);
    send_item(OP_GET, 16'sd15, 32'd0);
    send_item(3'd6, 16'sd0, 32'd0);
    send_item(3'd7, 16'sd0, 32'd0);
    send_item(OP_CLEAR, 16'sd0, 32'd0);
    send_item(OP_GET, 16'sd0, 32'd0);
    send_item(OP_SET, 16'sd5, 32'd0);
    send_item(OP_CONTAINS, 16'sd0, 32'd0);
  endtask

  // register extremes, including out-of-range values that clamp
  task automatic test_shape_extremes();
    logic [CFG_W-1:0] shapes [5][2];
    shapes = '{'{7'd0, 7'd0}, '{7'd64, 7'd1}, '{7'd1, 7'd64},
               '{7'd127, 7'd100}, '{7'd65, 7'd3}};
    foreach (shapes[s]) begin
      set_shape(shapes[s][0], shapes[s][1]);
      repeat (s == 3 ? 80 : 40) random_item();
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 20; p++) begin
      gaps_on = (p % 4) != 1;
      if ($urandom_range(0, 1)) write_reg(REG_FRAG_COUNT, CFG_W'($urandom_range(1, 12)));
      else write_reg(REG_FRAG_SIZE, CFG_W'($urandom_range(1, 12)));
      if (p % 5 == 0) set_shape(CFG_W'($urandom), CFG_W'($urandom_range(1, 8)));
      repeat (60) random_item();
    end
  endtask

  // compare each reply against the oldest expectation
  always @(posedge clk) begin
    array_reply_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_read_value, out_found, out_element_count,
              out_active_fragments, out_allocated_cells, out_capacity, out_fragment_event};
      replies_seen++;
      if (got.fragment_event == EV_SPAWN) spawns_seen++;
      if (got.fragment_event == EV_FREE) frees_seen++;
      if (pending_replies.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: st %0d/%0d val %h/%h fnd %0d/%0d cnt %0d/%0d",
                      " act %0d/%0d alc %0d/%0d cap %0d/%0d ev %0d/%0d"},
                     want.status, got.status, want.read_value, got.read_value,
                     want.found, got.found, want.element_count, got.element_count,
                     want.active_fragments, got.active_fragments,
                     want.allocated_cells, got.allocated_cells,
                     want.capacity, got.capacity, want.fragment_event, got.fragment_event);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; mismatches = 0; items_sent = 0; replies_seen = 0;
    spawns_seen = 0; frees_seen = 0; idle_cycles = 0;
    burst_left = 0; gaps_on = 1'b1;
    frag_cnt = 1; frag_len = 1;
    wipe_array();
    key_pool = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                 32'h55aa55aa, KEY_W'($urandom), KEY_W'($urandom)};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_shape_extremes();
    test_random();
    set_shape(7'd64, 7'd64);
    repeat (80) random_item();
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("sent %0d items, checked %0d replies", items_sent, replies_seen);
    $display("saw %0d fragment spawns and %0d frees", spawns_seen, frees_seen);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fsa_pkg.sv
rtl/fragmented_sparse_array_core.sv
bench/tb_fragmented_sparse_array_core.sv
